// ===== rtl/lru_order_tracker_top_defines.svh =====
// Assertion macros for the LRU order tracker.
// Used by lru_order_tracker_top; expects clk and rst_n in scope.
`ifndef LRU_ORDER_TRACKER_TOP_DEFINES_SVH
`define LRU_ORDER_TRACKER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define LOT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define LOT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lot_pkg.sv =====
// Shared types and constants for the LRU order tracker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lot_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int SLOT_W    = 4;

  typedef enum logic {
    OP_TOUCH  = 1'b0,
    OP_REMOVE = 1'b1
  } lot_op_t;

  // Link table and membership write controls for one word.
  typedef struct packed {
    logic next_p_en;   // next link of the predecessor takes the successor
    logic prev_n_en;   // prev link of the successor takes the predecessor
    logic link_s_en;   // slot is relinked at the head
    logic prev_h_en;   // prev link of the old head takes the slot
    logic set_member;
    logic clr_member;
  } lot_wr_t;

endpackage

// ===== rtl/lru_order_tracker_top.sv =====
// LRU order tracker: doubly linked recency list over SLOTS slots.
// A word is registered in the input stage, then its result is registered in
// the result register, which holds it while out_stall is high.
// One word per cycle while out_stall is low; link tables update as a word fires.
// Reset (synchronous, rst_n low): list empty, head and tail null, no words held.
// Link tables are not cleared; only member slots' links are ever read.
`timescale 1ns / 1ps
`include "lru_order_tracker_top_defines.svh"

module lru_order_tracker_top #(
  parameter int SLOTS = lot_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [lot_pkg::SLOT_W-1:0]   in_slot,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_was_present,
  output logic [lot_pkg::SLOT_W-1:0]   out_head_slot,
  output logic [lot_pkg::SLOT_W-1:0]   out_tail_slot,
  output logic                         out_list_empty,
  output logic                         out_remove_ignored
);

  localparam int LW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(SLOTS);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  // Input stage
  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  logic                        s1_op_r;
  logic [lot_pkg::SLOT_W-1:0]  s1_slot_r;
  logic                        s1_adv;
  logic                        fire;
  logic                        in_take;

  // List state
  logic [LW-1:0]     next_link_r   [SLOTS];
  logic [LW-1:0]     next_link_nxt [SLOTS];
  logic [LW-1:0]     prev_link_r   [SLOTS];
  logic [LW-1:0]     prev_link_nxt [SLOTS];
  logic [SLOTS-1:0]  in_list_r;
  logic [SLOTS-1:0]  in_list_nxt;
  logic [LW-1:0]     head_r;
  logic [LW-1:0]     tail_r;
  logic [LW-1:0]     head_nxt;
  logic [LW-1:0]     tail_nxt;

  logic              slot_ok;
  logic [LW-1:0]     s_link;
  logic [IW-1:0]     s_idx;
  logic              present;
  logic [LW-1:0]     p_link;
  logic [LW-1:0]     n_link;
  logic              ignored;
  lot_pkg::lot_wr_t  wr;

  assign in_stall     = s1_valid_r && !s1_adv;
  assign in_take      = in_valid && !in_stall;
  assign fire         = s1_valid_r && s1_adv;
  assign s1_valid_nxt = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_op;
      s1_slot_r <= in_slot;
    end
  end

  // Slot decode and link lookup
  assign slot_ok = (32'(s1_slot_r) < 32'(SLOTS));
  assign s_link  = slot_ok ? LW'(s1_slot_r) : NIL;
  assign s_idx   = s_link[IW-1:0];
  assign present = slot_ok && in_list_r[s_idx];
  assign p_link  = prev_link_r[s_idx];
  assign n_link  = next_link_r[s_idx];

  lot_link_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .op       (s1_op_r),
    .slot_ok  (slot_ok),
    .present  (present),
    .s_link   (s_link),
    .p_link   (p_link),
    .n_link   (n_link),
    .head_r   (head_r),
    .tail_r   (tail_r),
    .wr       (wr),
    .head_nxt (head_nxt),
    .tail_nxt (tail_nxt),
    .ignored  (ignored)
  );

  // Per-entry table update; the old head's back link wins over the unlink write.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      next_link_nxt[i] = next_link_r[i];
      prev_link_nxt[i] = prev_link_r[i];
      in_list_nxt[i]   = in_list_r[i];
      if (wr.next_p_en && (p_link == LW'(i))) begin
        next_link_nxt[i] = n_link;
      end
      if (wr.link_s_en && (s_link == LW'(i))) begin
        next_link_nxt[i] = head_r;
      end
      if (wr.prev_n_en && (n_link == LW'(i))) begin
        prev_link_nxt[i] = p_link;
      end
      if (wr.link_s_en && (s_link == LW'(i))) begin
        prev_link_nxt[i] = NIL;
      end
      if (wr.prev_h_en && (head_r == LW'(i))) begin
        prev_link_nxt[i] = s_link;
      end
      if (wr.set_member && (s_link == LW'(i))) begin
        in_list_nxt[i] = 1'b1;
      end
      if (wr.clr_member && (s_link == LW'(i))) begin
        in_list_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < SLOTS; i++) begin
        next_link_r[i] <= next_link_nxt[i];
        prev_link_r[i] <= prev_link_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_list_r <= '0;
      head_r    <= NIL;
      tail_r    <= NIL;
    end else if (fire) begin
      in_list_r <= in_list_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
    end
  end

  lot_result_reg #(
    .SLOTS (SLOTS)
  ) u_result (
    .clk                (clk),
    .rst_n              (rst_n),
    .s1_valid           (s1_valid_r),
    .s1_adv             (s1_adv),
    .present            (present),
    .ignored            (ignored),
    .head_nxt           (head_nxt),
    .tail_nxt           (tail_nxt),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_was_present    (out_was_present),
    .out_head_slot      (out_head_slot),
    .out_tail_slot      (out_tail_slot),
    .out_list_empty     (out_list_empty),
    .out_remove_ignored (out_remove_ignored)
  );

  `LOT_ASSERT_NOW(a_ends_null_together, 1'b1, (head_r == NIL) == (tail_r == NIL), "head and tail disagree on empty list")
  `LOT_ASSERT_NOW(a_members_match_head, 1'b1, (in_list_r == '0) == (head_r == NIL), "membership bits disagree with head pointer")
  `LOT_ASSERT_NEXT(a_touch_to_head, fire && (s1_op_r == lot_pkg::OP_TOUCH) && slot_ok, head_r == $past(s_link), "touched slot is not at head")
  `LOT_ASSERT_NEXT(a_remove_clears, fire && (s1_op_r == lot_pkg::OP_REMOVE) && present, !in_list_r[$past(s_idx)], "removed slot still a member")

endmodule

// ===== rtl/lot_link_ctrl.sv =====
// Link update decision for one operation: table write enables, new head/tail and the ignored flag.
// Depends on lot_pkg.
`timescale 1ns / 1ps

module lot_link_ctrl #(
  parameter int SLOTS = lot_pkg::SLOTS_DEF
) (
  input  logic                         op,
  input  logic                         slot_ok,
  input  logic                         present,
  input  logic [$clog2(SLOTS+1)-1:0]   s_link,
  input  logic [$clog2(SLOTS+1)-1:0]   p_link,
  input  logic [$clog2(SLOTS+1)-1:0]   n_link,
  input  logic [$clog2(SLOTS+1)-1:0]   head_r,
  input  logic [$clog2(SLOTS+1)-1:0]   tail_r,
  output lot_pkg::lot_wr_t             wr,
  output logic [$clog2(SLOTS+1)-1:0]   head_nxt,
  output logic [$clog2(SLOTS+1)-1:0]   tail_nxt,
  output logic                         ignored
);

  localparam int LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  logic touch;
  logic mv;
  logic ins;
  logic rm;
  logic unl;

  assign touch = (op == lot_pkg::OP_TOUCH);
  assign mv    = touch && present && (head_r != s_link);
  assign ins   = touch && slot_ok && !present;
  assign rm    = !touch && present;
  assign unl   = mv || rm;

  always_comb begin
    wr.next_p_en  = unl && (head_r != s_link) && (p_link < NIL);
    wr.prev_n_en  = unl && (tail_r != s_link) && (n_link < NIL);
    wr.link_s_en  = mv || ins;
    wr.prev_h_en  = (mv || ins) && (head_r < NIL);
    wr.set_member = ins;
    wr.clr_member = rm;
  end

  always_comb begin
    if (mv || ins) begin
      head_nxt = s_link;
    end else if (rm && (head_r == s_link)) begin
      head_nxt = n_link;
    end else begin
      head_nxt = head_r;
    end
  end

  always_comb begin
    if (ins && (head_r == NIL)) begin
      tail_nxt = s_link;
    end else if (unl && (tail_r == s_link)) begin
      tail_nxt = p_link;
    end else begin
      tail_nxt = tail_r;
    end
  end

  assign ignored = !touch && !present;

endmodule

// ===== rtl/lot_result_reg.sv =====
// Result register: formats head/tail/empty and holds the word under stall.
// Depends on lot_pkg.
`timescale 1ns / 1ps

module lot_result_reg #(
  parameter int SLOTS = lot_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               s1_valid,
  output logic                               s1_adv,
  input  logic                               present,
  input  logic                               ignored,
  input  logic [$clog2(SLOTS+1)-1:0]         head_nxt,
  input  logic [$clog2(SLOTS+1)-1:0]         tail_nxt,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_was_present,
  output logic [lot_pkg::SLOT_W-1:0]         out_head_slot,
  output logic [lot_pkg::SLOT_W-1:0]         out_tail_slot,
  output logic                               out_list_empty,
  output logic                               out_remove_ignored
);

  localparam int LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  logic                        valid_r;
  logic                        valid_nxt;
  logic                        present_r;
  logic                        ignored_r;
  logic                        empty_r;
  logic [lot_pkg::SLOT_W-1:0]  head_r;
  logic [lot_pkg::SLOT_W-1:0]  tail_r;
  logic                        empty;

  assign s1_adv    = !valid_r || !out_stall;
  assign valid_nxt = s1_adv ? s1_valid : valid_r;
  assign empty     = (head_nxt == NIL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load only when a word moves in; hold otherwise.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      present_r <= present;
      ignored_r <= ignored;
      empty_r   <= empty;
      head_r    <= empty ? '0 : lot_pkg::SLOT_W'(head_nxt);
      tail_r    <= empty ? '0 : lot_pkg::SLOT_W'(tail_nxt);
    end
  end

  assign out_valid          = valid_r;
  assign out_was_present    = present_r;
  assign out_head_slot      = head_r;
  assign out_tail_slot      = tail_r;
  assign out_list_empty     = empty_r;
  assign out_remove_ignored = ignored_r;

endmodule
